// ===== hw/rtl/tlv_key_value_stream_parser_assert.svh =====
// assertion macros used by the port-level checker of the key-value stream parser
`ifndef TLV_KEY_VALUE_STREAM_PARSER_ASSERT_SVH
`define TLV_KEY_VALUE_STREAM_PARSER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TLV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlv parser check failed");

// antecedent implies consequent in the next cycle
`define TLV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlv parser check failed");

`endif

// ===== hw/rtl/tlv_pkg.sv =====
// shared types and constants of the key-value stream parser
package tlv_pkg;

    // result kinds
    localparam logic [2:0] KIND_INT32   = 3'd0;
    localparam logic [2:0] KIND_INT64   = 3'd1;
    localparam logic [2:0] KIND_HEADER  = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_END_OK  = 3'd4;
    localparam logic [2:0] KIND_END_ERR = 3'd5;

    // header type field mask
    localparam logic [2:0] TYPE_MASK = 3'h7;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [2:0]         record_kind;
        logic [12:0]        field_key;
        logic signed [63:0] int_value;
        logic [31:0]        payload_length;
        logic [7:0]         payload_byte;
        logic               last_payload;
        logic               run_last;
    } out_beat_t;

    // work for the back end caused by one input byte
    typedef struct packed {
        logic        has_rec;
        logic [2:0]  rec_kind;
        logic [12:0] rec_key;
        logic [63:0] rec_value;
        logic        rec_lastp;
        logic        has_end;
        logic        end_ok;
    } queue_entry_t;

endpackage

// ===== hw/rtl/tlv_front.sv =====
// front end: byte intake, record parsing and queue entry build
module tlv_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tlv_pkg::in_beat_t     s_data,
    input  logic                  push_ready,
    output logic                  push_valid,
    output tlv_pkg::queue_entry_t push_entry
);

    // parse phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_VALUE   = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // header type codes
    localparam logic [2:0] HT_INT32 = 3'd0;
    localparam logic [2:0] HT_INT64 = 3'd1;
    localparam logic [2:0] HT_BYTES = 3'd2;

    logic        net_order_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [63:0] shift_reg, shift_next;
    logic [3:0]  count_reg, count_next;
    logic [12:0] key_reg, key_next;
    logic        long_reg, long_next;
    logic [31:0] remaining_reg, remaining_next;
    logic        error_reg, error_next;

    logic        accept;
    logic [63:0] take_shift;
    logic [3:0]  take_count;
    logic [15:0] hdr;
    logic [2:0]  htype;
    logic [31:0] rem_dec;
    tlv_pkg::queue_entry_t entry;

    assign cfg_ready = 1'b1;
    assign s_ready   = push_ready;
    assign accept    = s_valid && s_ready;

    // byte order register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            net_order_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            net_order_reg <= cfg_data;
        end
    end

    // next assembly word with the current byte taken in
    always_comb begin
        if (net_order_reg) begin
            take_shift = {shift_reg[55:0], s_data.data_byte};
        end else begin
            take_shift = shift_reg | ({56'd0, s_data.data_byte} << {count_reg[2:0], 3'b000});
        end
        take_count = count_reg + 4'd1;
        hdr        = take_shift[15:0];
        htype      = hdr[2:0] & tlv_pkg::TYPE_MASK;
        rem_dec    = remaining_reg - 32'd1;
    end

    // parse step
    always_comb begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        long_next      = long_reg;
        remaining_next = remaining_reg;
        error_next     = error_reg;
        entry          = '0;
        entry.rec_key  = key_reg;
        if (accept) begin
            if (!error_reg) begin
                unique case (phase_reg)
                    PH_HDR0: begin
                        shift_next = {56'd0, s_data.data_byte};
                        count_next = 4'd1;
                        phase_next = PH_HDR1;
                    end
                    PH_HDR1: begin
                        key_next   = hdr[15:3];
                        shift_next = '0;
                        count_next = '0;
                        unique case (htype)
                            HT_INT32: begin
                                long_next  = 1'b0;
                                phase_next = PH_VALUE;
                            end
                            HT_INT64: begin
                                long_next  = 1'b1;
                                phase_next = PH_VALUE;
                            end
                            HT_BYTES: begin
                                phase_next = PH_LEN;
                            end
                            default: begin
                                error_next = 1'b1;
                            end
                        endcase
                    end
                    PH_VALUE: begin
                        shift_next = take_shift;
                        count_next = take_count;
                        if (!long_reg && take_count == 4'd4) begin
                            entry.has_rec   = 1'b1;
                            entry.rec_kind  = tlv_pkg::KIND_INT32;
                            entry.rec_value = {{32{take_shift[31]}}, take_shift[31:0]};
                            phase_next      = PH_HDR0;
                        end else if (long_reg && take_count == 4'd8) begin
                            entry.has_rec   = 1'b1;
                            entry.rec_kind  = tlv_pkg::KIND_INT64;
                            entry.rec_value = take_shift;
                            phase_next      = PH_HDR0;
                        end
                    end
                    PH_LEN: begin
                        shift_next = take_shift;
                        count_next = take_count;
                        if (take_count == 4'd4) begin
                            remaining_next  = take_shift[31:0];
                            entry.has_rec   = 1'b1;
                            entry.rec_kind  = tlv_pkg::KIND_HEADER;
                            entry.rec_value = {32'd0, take_shift[31:0]};
                            phase_next      = (take_shift[31:0] != 32'd0) ? PH_PAYLOAD : PH_HDR0;
                        end
                    end
                    default: begin
                        remaining_next  = rem_dec;
                        entry.has_rec   = 1'b1;
                        entry.rec_kind  = tlv_pkg::KIND_PAYLOAD;
                        entry.rec_value = {56'd0, s_data.data_byte};
                        entry.rec_lastp = (rem_dec == 32'd0);
                        if (rem_dec == 32'd0) begin
                            phase_next = PH_HDR0;
                        end
                    end
                endcase
            end
            // end of buffer: status then back to a clean parse state
            if (s_data.end_of_buffer) begin
                entry.has_end  = 1'b1;
                entry.end_ok   = !error_next && (phase_next == PH_HDR0);
                phase_next     = PH_HDR0;
                shift_next     = '0;
                count_next     = '0;
                key_next       = '0;
                long_next      = 1'b0;
                remaining_next = '0;
                error_next     = 1'b0;
            end
        end
    end

    assign push_valid = accept && (entry.has_rec || entry.has_end);
    assign push_entry = entry;

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            shift_reg     <= '0;
            count_reg     <= '0;
            key_reg       <= '0;
            long_reg      <= 1'b0;
            remaining_reg <= '0;
            error_reg     <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            key_reg       <= key_next;
            long_reg      <= long_next;
            remaining_reg <= remaining_next;
            error_reg     <= error_next;
        end
    end

endmodule

// ===== hw/rtl/tlv_fifo.sv =====
// short queue of parsed entries between front and back
module tlv_fifo #(
    parameter int DEPTH = tlv_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  tlv_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output logic                  head_valid,
    output tlv_pkg::queue_entry_t head_entry
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    tlv_pkg::queue_entry_t entries [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CntW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/tlv_back.sv =====
// back end: expands queue entries into result beats behind an output register
module tlv_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  tlv_pkg::queue_entry_t head_entry,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tlv_pkg::out_beat_t    m_data
);

    logic                m_valid_reg, m_valid_next;
    logic                rec_sent_reg, rec_sent_next;
    tlv_pkg::out_beat_t  m_data_reg, m_data_next;
    tlv_pkg::out_beat_t  rec_beat;
    logic                load;

    assign load    = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // record beat from the head entry
    always_comb begin
        rec_beat             = '0;
        rec_beat.record_kind = head_entry.rec_kind;
        rec_beat.field_key   = head_entry.rec_key;
        rec_beat.run_last    = !head_entry.has_end;
        case (head_entry.rec_kind) inside
            tlv_pkg::KIND_INT32, tlv_pkg::KIND_INT64: begin
                rec_beat.int_value = $signed(head_entry.rec_value);
            end
            tlv_pkg::KIND_HEADER: begin
                rec_beat.payload_length = head_entry.rec_value[31:0];
            end
            tlv_pkg::KIND_PAYLOAD: begin
                rec_beat.payload_byte = head_entry.rec_value[7:0];
                rec_beat.last_payload = head_entry.rec_lastp;
            end
            default: begin
            end
        endcase
    end

    // beat selection: record first, then end status of the same byte
    always_comb begin
        pop           = 1'b0;
        rec_sent_next = rec_sent_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        if (load && head_valid) begin
            m_valid_next = 1'b1;
            if (head_entry.has_rec && !rec_sent_reg) begin
                m_data_next = rec_beat;
                if (head_entry.has_end) begin
                    rec_sent_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                m_data_next             = '0;
                m_data_next.record_kind = head_entry.end_ok ? tlv_pkg::KIND_END_OK
                                                            : tlv_pkg::KIND_END_ERR;
                m_data_next.run_last    = 1'b1;
                pop                     = 1'b1;
                rec_sent_next           = 1'b0;
            end
        end
    end

    // output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            rec_sent_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            rec_sent_reg <= rec_sent_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hw/rtl/tlv_key_value_stream_parser.sv =====
// top level of the key-value record stream parser
// Takes one buffer byte per cycle on s_ (valid/ready) and gives zero, one or two
// result beats per byte on m_, one beat per cycle while m_ready is high; a byte that gives an integer,
// a bytes header or a payload byte and also ends the buffer gives two beats, the
// second being the end status. With the queue empty and the output register free,
// a result goes through the queue and the output register to m_. The front parser
// takes a byte every cycle while the QUEUE_DEPTH entry queue to the output side
// has room; s_ready drops only when the queue is full, i.e. when m_ready has been
// held low or two-beat bytes outpace the output.
// The byte order bit is written through cfg_ (always ready, resets to big-endian)
// and must only change while the parser is idle. No clearing pass after reset.
module tlv_key_value_stream_parser #(
    parameter int QUEUE_DEPTH = tlv_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  tlv_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tlv_pkg::out_beat_t m_data
);

    logic                  push_valid, push_ready;
    tlv_pkg::queue_entry_t push_entry;
    logic                  pop, head_valid;
    tlv_pkg::queue_entry_t head_entry;

    // byte parser
    tlv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    // decoupling queue
    tlv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // result emitter
    tlv_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== hw/rtl/tlv_checker.sv =====
// port-level checks of the key-value stream parser and their bind
`include "tlv_key_value_stream_parser_assert.svh"

module tlv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               m_valid,
    input logic               m_ready,
    input tlv_pkg::out_beat_t m_data
);

    // stalled result beat holds
    `TLV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // a byte's second beat follows its first without a gap
    `TLV_ASSERT_NEXT(a_run_cont, aclk, aresetn, m_valid && m_ready && !m_data.run_last, m_valid)

    // end status always closes the run of its byte
    `TLV_ASSERT_SAME(a_end_last, aclk, aresetn, m_valid && (m_data.record_kind == tlv_pkg::KIND_END_OK || m_data.record_kind == tlv_pkg::KIND_END_ERR), m_data.run_last)

    // last payload flag only on payload beats
    `TLV_ASSERT_SAME(a_lastp_kind, aclk, aresetn, m_valid && m_data.last_payload, m_data.record_kind == tlv_pkg::KIND_PAYLOAD)

    // configuration writes never stall
    `TLV_ASSERT_SAME(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind tlv_key_value_stream_parser tlv_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

// ===== tb/sv/tlv_tb_pkg.sv =====
// header type codes of the serialized key-value buffer, shared by the test files
package tlv_tb_pkg;

    // type field of a record header as it appears on the wire
    localparam logic [2:0] WIRE_INT32 = 3'd0;
    localparam logic [2:0] WIRE_INT64 = 3'd1;
    localparam logic [2:0] WIRE_BYTES = 3'd2;

endpackage

// ===== tb/sv/tlv_key_value_stream_parser_checker.sv =====
// channel monitor that predicts and checks every result beat of the key-value parser
module tlv_key_value_stream_parser_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  tlv_pkg::in_beat_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  tlv_pkg::out_beat_t m_data,
    output int                 fail_count,
    output int                 pending
);
    import tlv_pkg::*;
    import tlv_tb_pkg::*;

    typedef enum logic [2:0] {
        AT_HDR0,
        AT_HDR1,
        AT_VALUE,
        AT_LEN,
        AT_PAYLOAD
    } parse_phase_e;

    // predicted parser state
    logic         big_endian;
    parse_phase_e phase;
    logic [63:0]  shift_acc;
    logic [3:0]   taken;
    logic [12:0]  rec_key;
    logic [2:0]   rec_type;
    logic [31:0]  bytes_left;
    logic         broken;

    out_beat_t expected_beats[$];
    int        mismatches = 0;

    // back to the start of a buffer
    task automatic clear_parse();
        phase      = AT_HDR0;
        shift_acc  = '0;
        taken      = '0;
        rec_key    = '0;
        rec_type   = '0;
        bytes_left = '0;
        broken     = 1'b0;
    endtask

    // fold one byte into the field being assembled
    task automatic take_byte(input logic [7:0] value);
        if (big_endian) begin
            shift_acc = {shift_acc[55:0], value};
        end else begin
            shift_acc = shift_acc | (64'(value) << (taken[2:0] * 8));
        end
        taken = taken + 4'd1;
    endtask

    function automatic out_beat_t make_beat(input logic [2:0] kind, input logic [12:0] key,
                                            input logic [63:0] val, input logic [31:0] len,
                                            input logic [7:0] pb, input logic lastp);
        out_beat_t r;
        r.record_kind    = kind;
        r.field_key      = key;
        r.int_value      = val;
        r.payload_length = len;
        r.payload_byte   = pb;
        r.last_payload   = lastp;
        r.run_last       = 1'b0;
        return r;
    endfunction

    // advance the parse by one accepted input beat and queue its results
    task automatic predict(input in_beat_t beat);
        out_beat_t   fresh [2];
        int          made;
        logic [15:0] hdr;
        made = 0;
        if (!broken) begin
            case (phase)
                AT_HDR0: begin
                    shift_acc = '0;
                    taken     = '0;
                    take_byte(beat.data_byte);
                    phase = AT_HDR1;
                end
                AT_HDR1: begin
                    take_byte(beat.data_byte);
                    hdr       = shift_acc[15:0];
                    rec_key   = hdr[15:3];
                    shift_acc = '0;
                    taken     = '0;
                    case (hdr[2:0])
                        WIRE_INT32, WIRE_INT64: begin
                            rec_type = hdr[2:0];
                            phase    = AT_VALUE;
                        end
                        WIRE_BYTES: begin
                            rec_type = hdr[2:0];
                            phase    = AT_LEN;
                        end
                        default: begin
                            broken = 1'b1;
                        end
                    endcase
                end
                AT_VALUE: begin
                    take_byte(beat.data_byte);
                    if (rec_type == WIRE_INT32 && taken == 4'd4) begin
                        fresh[made] = make_beat(KIND_INT32, rec_key,
                                                {{32{shift_acc[31]}}, shift_acc[31:0]},
                                                '0, '0, 1'b0);
                        made  = made + 1;
                        phase = AT_HDR0;
                    end else if (rec_type != WIRE_INT32 && taken == 4'd8) begin
                        fresh[made] = make_beat(KIND_INT64, rec_key, shift_acc, '0, '0, 1'b0);
                        made  = made + 1;
                        phase = AT_HDR0;
                    end
                end
                AT_LEN: begin
                    take_byte(beat.data_byte);
                    if (taken == 4'd4) begin
                        bytes_left  = shift_acc[31:0];
                        fresh[made] = make_beat(KIND_HEADER, rec_key, '0, bytes_left, '0, 1'b0);
                        made  = made + 1;
                        phase = (bytes_left != 0) ? AT_PAYLOAD : AT_HDR0;
                    end
                end
                default: begin
                    bytes_left  = bytes_left - 32'd1;
                    fresh[made] = make_beat(KIND_PAYLOAD, rec_key, '0, '0, beat.data_byte,
                                            bytes_left == 0);
                    made = made + 1;
                    if (bytes_left == 0) begin
                        phase = AT_HDR0;
                    end
                end
            endcase
        end
        // end status follows any record result of the final byte
        if (beat.end_of_buffer) begin
            fresh[made] = make_beat((!broken && phase == AT_HDR0) ? KIND_END_OK : KIND_END_ERR,
                                    '0, '0, '0, '0, 1'b0);
            made = made + 1;
            clear_parse();
        end
        if (made > 0) begin
            fresh[made - 1].run_last = 1'b1;
        end
        for (int i = 0; i < made; i++) begin
            expected_beats.push_back(fresh[i]);
        end
    endtask

    // compare one result beat with the oldest prediction
    task automatic check_result(input out_beat_t got);
        out_beat_t  want;
        logic [6:0] bad;
        if (expected_beats.size() == 0) begin
            if (mismatches < 10) begin
                $display("unexpected result beat: kind %0d key %0h value %0h",
                         got.record_kind, got.field_key, got.int_value);
            end
            mismatches = mismatches + 1;
        end else begin
            want = expected_beats.pop_front();
            bad = {got.record_kind !== want.record_kind, got.field_key !== want.field_key,
                   got.int_value !== want.int_value,
                   got.payload_length !== want.payload_length,
                   got.payload_byte !== want.payload_byte,
                   got.last_payload !== want.last_payload, got.run_last !== want.run_last};
            if (bad != 0) begin
                if (mismatches < 10) begin
                    $display("result mismatch, fields %b (expected/actual):", bad);
                    $display("  kind %0d/%0d key %0h/%0h value %0h/%0h",
                             want.record_kind, got.record_kind, want.field_key, got.field_key,
                             want.int_value, got.int_value);
                    $display("  length %0h/%0h byte %0h/%0h last_payload %b/%b run_last %b/%b",
                             want.payload_length, got.payload_length, want.payload_byte,
                             got.payload_byte, want.last_payload, got.last_payload,
                             want.run_last, got.run_last);
                end
                mismatches = mismatches + 1;
            end
        end
    endtask

    // watch the three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            big_endian = 1'b1;
            clear_parse();
            expected_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                big_endian = cfg_data;
            end
            if (s_valid && s_ready) begin
                predict(s_data);
            end
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
        end
        fail_count <= mismatches;
        pending    <= expected_beats.size();
    end

endmodule

// ===== tb/sv/tlv_key_value_stream_parser_tb.sv =====
// stimulus and verdict for the key-value record stream parser
module tlv_key_value_stream_parser_tb;
    import tlv_pkg::*;
    import tlv_tb_pkg::*;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_data  = 1'b0;
    logic      s_valid   = 1'b0;
    in_beat_t  s_data    = '0;
    logic      m_ready   = 1'b0;
    logic      cfg_ready;
    logic      s_ready;
    logic      m_valid;
    out_beat_t m_data;

    int fail_count;
    int pending;

    // byte order used to build buffers, tracks the register
    logic wire_big      = 1'b1;
    // phase with no idling on either side
    logic calm          = 1'b0;
    logic squeeze_armed = 1'b0;
    logic squeeze_done  = 1'b0;

    logic [7:0] buffer_bytes[$];
    int         beats_sent;

    always #5 aclk = ~aclk;

    tlv_key_value_stream_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    tlv_key_value_stream_parser_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // offer one input beat, with random idle cycles in front of it
    task automatic send_byte(input logic [7:0] value, input logic last);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 17) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{data_byte: value, end_of_buffer: last};
        do @(posedge aclk); while (!s_ready);
        beats_sent = beats_sent + 1;
    endtask

    // append a multi-byte field in the current byte order
    task automatic push_field(input logic [63:0] value, input int count);
        if (wire_big) begin
            for (int i = count - 1; i >= 0; i--) begin
                buffer_bytes.push_back(value[i*8 +: 8]);
            end
        end else begin
            for (int i = 0; i < count; i++) begin
                buffer_bytes.push_back(value[i*8 +: 8]);
            end
        end
    endtask

    // send the built buffer, final byte flagged
    task automatic send_buffer();
        for (int i = 0; i < buffer_bytes.size(); i++) begin
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
        end
        buffer_bytes.delete();
    endtask

    // mostly well-formed buffers, some truncated, broken or pure noise
    task automatic build_random_buffer();
        int          fate;
        int          len;
        logic [2:0]  kind;
        logic [12:0] key;
        fate = $urandom_range(99);
        if (fate >= 97) begin
            repeat ($urandom_range(1, 12)) buffer_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                kind = 3'($urandom_range(WIRE_BYTES));
                key  = 13'($urandom);
                push_field(64'({key, kind}), 2);
                case (kind)
                    WIRE_INT32: push_field(64'($urandom), 4);
                    WIRE_INT64: push_field({$urandom, $urandom}, 8);
                    default: begin
                        len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(4);
                        push_field(64'(len), 4);
                        repeat (len) buffer_bytes.push_back(8'($urandom));
                    end
                endcase
            end
            if (fate >= 76 && fate < 86) begin
                // bytes record with a full-range length, cut off by the buffer end
                push_field(64'({13'($urandom), WIRE_BYTES}), 2);
                push_field(64'($urandom), 4);
                repeat ($urandom_range(3)) buffer_bytes.push_back(8'($urandom));
            end else if (fate >= 86 && fate < 93) begin
                repeat ($urandom_range(1, buffer_bytes.size() - 1)) void'(buffer_bytes.pop_back());
            end else if (fate >= 93) begin
                // unknown type, then bytes that are skipped
                push_field(64'({13'($urandom),
                                3'($urandom_range(WIRE_BYTES + 1, TYPE_MASK))}), 2);
                repeat ($urandom_range(5)) buffer_bytes.push_back(8'($urandom));
            end
        end
    endtask

    task automatic random_phase(input int target);
        beats_sent = 0;
        while (beats_sent < target) begin
            build_random_buffer();
            send_buffer();
        end
    endtask

    // wait for every predicted result, then let the pipeline settle
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_order(input logic value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        wire_big  = value;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (squeeze_armed && !squeeze_done) begin
                m_ready = 1'b0;
                repeat (63) @(negedge aclk);
                squeeze_done = 1'b1;
            end else begin
                m_ready = calm || ($urandom_range(99) >= 17);
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // int32 of the largest key and most negative value, ends the buffer
        push_field(64'({13'h1FFF, WIRE_INT32}), 2);
        push_field(64'h8000_0000, 4);
        send_buffer();
        // empty payload
        push_field(64'({13'h0AAA, WIRE_BYTES}), 2);
        push_field(64'd0, 4);
        send_buffer();
        // one payload byte on the final byte of the buffer
        push_field(64'({13'h0000, WIRE_BYTES}), 2);
        push_field(64'd1, 4);
        push_field(64'hFF, 1);
        send_buffer();
        // unknown type, following byte ignored
        push_field(64'({13'h1555, TYPE_MASK}), 2);
        buffer_bytes.push_back(8'h00);
        send_buffer();
        // buffer that ends inside a header
        buffer_bytes.push_back(8'hA5);
        send_buffer();

        random_phase(120);
        drain();
        write_order(1'b0);
        squeeze_armed = 1'b1;
        random_phase(130);
        drain();
        write_order(1'b1);
        calm = 1'b1;
        random_phase(120);
        drain();
        calm = 1'b0;
        write_order(1'b0);
        random_phase(120);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tlv_key_value_stream_parser_tb passed");
        end else begin
            $display("tlv_key_value_stream_parser_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tlv_key_value_stream_parser_tb failed");
        $finish;
    end

endmodule
